>>> sv/pfr_pkg.sv
// shared types and constants for the pelco-d / pelco-p receive framer
package pfr_pkg;

  localparam int D_FRAME_LEN     = 7;
  localparam int P_FRAME_LEN     = 8;
  localparam int MAX_FRAME_BYTES = 16;
  localparam int STORE_DEPTH     = 8;
  localparam int STORE_IDX_W     = $clog2(STORE_DEPTH);
  localparam int CNT_W           = 7;

  localparam int BYTE_W      = 8;
  localparam int WORD_W      = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int KIND_W      = 2;
  localparam int OUT_FIELD_W = 2 * WORD_W + 4;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_D_SYNC_BYTE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_P_SYNC_BYTE    = 2'd2;

  localparam logic [BYTE_W-1:0] DEVICE_ADDRESS_RST = 8'h01;
  localparam logic [BYTE_W-1:0] D_SYNC_BYTE_RST    = 8'hFF;
  localparam logic [BYTE_W-1:0] P_SYNC_BYTE_RST    = 8'hA0;

  typedef enum logic [KIND_W-1:0] {
    KIND_D    = 2'd0,
    KIND_P    = 2'd1,
    KIND_NONE = 2'd2
  } frame_kind_e;

  typedef struct packed {
    frame_kind_e       frame_kind;
    logic              check_ok;
    logic              addr_match;
    logic [WORD_W-1:0] command_word;
    logic [WORD_W-1:0] data_word;
    logic              stop_request;
    logic              frame_accepted;
  } result_t;

endpackage

>>> sv/pelco_dp_frame_receiver.sv
// pelco-d / pelco-p receive framer top level
//
// One received byte is taken per cycle on the slave stream while tready is
// high. A byte equal to the configured D or P sync byte restarts a frame of
// that kind (D wins when both match). A frame closes after 7 bytes (D), 8
// bytes (P), or at 16 bytes with no sync seen (reported as kind none, never
// accepted), and its result is registered into the output or skid register.
// The checksum, address compare and word fields are computed from the byte
// store plus the incoming byte in a single pass, so the sustained rate is one
// byte per cycle while tready is high. An output register backed by one skid
// register lets bytes keep flowing while a result waits; tready drops only
// when both hold an untaken result. Configuration writes take effect on the
// next cycle and are meant to happen while the block is idle.
module pelco_dp_frame_receiver (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [pfr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pfr_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // rx_byte [7:0]
  input  logic [pfr_pkg::BYTE_W-1:0]         s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // check_ok [0], addr_match [1], command_word [17:2], data_word [33:18],
  // stop_request [34], frame_accepted [35], zero [39:36]
  output logic [pfr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // frame_kind [1:0]
  output logic [pfr_pkg::KIND_W-1:0]         m_axis_tuser_o
);

  logic [pfr_pkg::BYTE_W-1:0] dev_addr_q, d_sync_q, p_sync_q;

  logic [pfr_pkg::CNT_W-1:0] cnt_q, cnt_base, cnt_d;
  pfr_pkg::frame_kind_e      kind_q, kind_cur, kind_d;
  logic [pfr_pkg::BYTE_W-1:0] store_q [pfr_pkg::STORE_DEPTH];
  logic [pfr_pkg::BYTE_W-1:0] store_d [pfr_pkg::STORE_DEPTH];

  pfr_pkg::result_t out_q, skid_q, res;
  logic             out_valid_q, skid_valid_q;

  logic accept, pop, push, done, hit_d, hit_p, ok;
  logic [pfr_pkg::BYTE_W-1:0] sum_d, xor_p;

  assign s_axis_tready_o = !skid_valid_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign pop             = out_valid_q && m_axis_tready_i;
  assign push            = accept && done;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= pfr_pkg::DEVICE_ADDRESS_RST;
      d_sync_q   <= pfr_pkg::D_SYNC_BYTE_RST;
      p_sync_q   <= pfr_pkg::P_SYNC_BYTE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pfr_pkg::REG_DEVICE_ADDRESS: dev_addr_q <= cfg_wdata_i;
        pfr_pkg::REG_D_SYNC_BYTE:    d_sync_q   <= cfg_wdata_i;
        pfr_pkg::REG_P_SYNC_BYTE:    p_sync_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // framing and result
  always_comb begin
    hit_d    = (s_axis_tdata_i == d_sync_q);
    hit_p    = !hit_d && (s_axis_tdata_i == p_sync_q);
    cnt_base = (hit_d || hit_p) ? '0 : cnt_q;
    kind_cur = hit_d ? pfr_pkg::KIND_D : (hit_p ? pfr_pkg::KIND_P : kind_q);

    for (int i = 0; i < pfr_pkg::STORE_DEPTH; i++) begin
      store_d[i] = store_q[i];
    end
    if (cnt_base < pfr_pkg::CNT_W'(pfr_pkg::STORE_DEPTH)) begin
      store_d[cnt_base[pfr_pkg::STORE_IDX_W-1:0]] = s_axis_tdata_i;
    end
    cnt_d = cnt_base + pfr_pkg::CNT_W'(1);

    done = (kind_cur == pfr_pkg::KIND_D && cnt_d == pfr_pkg::CNT_W'(pfr_pkg::D_FRAME_LEN)) ||
           (kind_cur == pfr_pkg::KIND_P && cnt_d == pfr_pkg::CNT_W'(pfr_pkg::P_FRAME_LEN)) ||
           (cnt_d >= pfr_pkg::CNT_W'(pfr_pkg::MAX_FRAME_BYTES));
    kind_d = done ? pfr_pkg::KIND_NONE : kind_cur;

    sum_d = '0;
    for (int i = 1; i < pfr_pkg::D_FRAME_LEN - 1; i++) begin
      sum_d = sum_d + store_d[i];
    end
    xor_p = '0;
    for (int i = 0; i < pfr_pkg::P_FRAME_LEN - 1; i++) begin
      xor_p = xor_p ^ store_d[i];
    end

    case (kind_cur)
      pfr_pkg::KIND_D: ok = (store_d[pfr_pkg::D_FRAME_LEN - 1] == sum_d);
      pfr_pkg::KIND_P: ok = (store_d[pfr_pkg::P_FRAME_LEN - 1] == xor_p);
      default:         ok = 1'b0;
    endcase

    res.frame_kind     = kind_cur;
    res.check_ok       = ok;
    res.addr_match     = (store_d[1] == dev_addr_q);
    res.command_word   = {store_d[2], store_d[3]};
    res.data_word      = {store_d[4], store_d[5]};
    res.stop_request   = (res.command_word == '0) && (res.data_word == '0);
    res.frame_accepted = (kind_cur != pfr_pkg::KIND_NONE) && ok && res.addr_match;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      kind_q <= pfr_pkg::KIND_NONE;
    end else if (accept) begin
      cnt_q  <= done ? '0 : cnt_d;
      kind_q <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      store_q <= store_d;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.frame_kind;
  assign m_axis_tdata_o  = {
    (pfr_pkg::OUT_TDATA_W - pfr_pkg::OUT_FIELD_W)'(0),
    out_q.frame_accepted,
    out_q.stop_request,
    out_q.data_word,
    out_q.command_word,
    out_q.addr_match,
    out_q.check_ok
  };

endmodule

>>> sv/pfr_checker.sv
// port-level assertions for the pelco-d / pelco-p receive framer
module pfr_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [pfr_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic [pfr_pkg::KIND_W-1:0]      m_axis_tuser_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // input back-pressure only while results are pending
  a_stall_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("tready low with no pending result");

  // accepted frames have a known kind, good checksum and address match
  a_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[35] |->
      m_axis_tdata_o[0] && m_axis_tdata_o[1] &&
      (m_axis_tuser_o == pfr_pkg::KIND_D || m_axis_tuser_o == pfr_pkg::KIND_P))
    else $error("frame accepted without its conditions");

  // overrun frames never pass the checksum
  a_none_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == pfr_pkg::KIND_NONE |-> !m_axis_tdata_o[0])
    else $error("overrun frame reports good checksum");

  // stop flag follows the command and data words
  a_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[34] == (m_axis_tdata_o[33:2] == 32'd0))
    else $error("stop flag mismatch");

endmodule

bind pelco_dp_frame_receiver pfr_checker u_pfr_checker (.*);
